### hw/rtl/cc20_pkg.sv
// cc20_pkg: shared types, constants and helpers for the chacha20 stream block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

	localparam int WORD_W          = 32;
	localparam int CNT_W           = 64;
	localparam int REG_W           = 64;
	localparam int ADDR_W          = 6;
	localparam int BYTES_W         = 3;
	localparam int POS_W           = 4;
	localparam int NWORDS          = 16;
	localparam int NLANES          = 4;
	localparam int ROUND_COUNT_DEF = 20;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t blk_t [NWORDS];
	typedef word_t lane_t [NLANES];

	localparam word_t SIGMA [NLANES] = '{
		32'h61707865, 32'h3320646E, 32'h79622D32, 32'h6B206574
	};

	// register map, one 64-bit register every 8 bytes
	typedef enum logic [2:0] {
		REG_KEY01 = 3'd0,
		REG_KEY23 = 3'd1,
		REG_KEY45 = 3'd2,
		REG_KEY67 = 3'd3,
		REG_NONCE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} fsm_t;

	// quarter-round sub-steps in order
	typedef enum logic [1:0] {
		QS_AB16,
		QS_CD12,
		QS_AB8,
		QS_CD7
	} qstep_t;

	// rows of the 4x4 state
	localparam logic [1:0] ROW_A = 2'd0;
	localparam logic [1:0] ROW_B = 2'd1;
	localparam logic [1:0] ROW_C = 2'd2;
	localparam logic [1:0] ROW_D = 2'd3;

	// word index of a row/lane; diagonal rounds shift row r by r lanes
	function automatic logic [POS_W-1:0] qr_index(logic [1:0] row, logic [1:0] lane,
		logic diag);
		logic [1:0] col;
		col = diag ? 2'(lane + row) : lane;
		return {row, col};
	endfunction

	// byte mask for a valid count, counts above four act as four
	function automatic word_t byte_mask(logic [BYTES_W-1:0] vb);
		word_t m;
		case (vb)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00FF;
			3'd2: m = 32'h0000_FFFF;
			3'd3: m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/cc20_stream_if.sv
// cc20_msg_if and cc20_res_if: valid/ready channels for message and result beats
// depends on cc20_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cc20_msg_if import cc20_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  msg_word;
	logic [BYTES_W-1:0] valid_bytes;
	logic               last_word;

	modport source(output valid, msg_word, valid_bytes, last_word, input ready);
	modport sink(input valid, msg_word, valid_bytes, last_word, output ready);
endinterface

interface cc20_res_if import cc20_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  cipher_word;
	logic [BYTES_W-1:0] out_bytes;
	logic               out_last;
	logic               counter_overflow;

	modport source(output valid, cipher_word, out_bytes, out_last, counter_overflow,
		input ready);
	modport sink(input valid, cipher_word, out_bytes, out_last, counter_overflow,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/cc20_qr_unit.sv
// cc20_qr_unit: one quarter-round sub-step on four lanes at once
// depends on cc20_pkg
`timescale 1ns / 1ps
`default_nettype none

module cc20_qr_unit import cc20_pkg::*; (
	input  qstep_t step,
	input  lane_t  x,
	input  lane_t  y,
	input  lane_t  z,
	output lane_t  x_new,
	output lane_t  z_new
);

	word_t sum [NLANES];
	word_t mix [NLANES];

	// x += y; z = rotl(z ^ x, r)
	always_comb begin
		for (int j = 0; j < NLANES; j++) begin
			sum[j] = x[j] + y[j];
			mix[j] = z[j] ^ sum[j];
			x_new[j] = sum[j];
			case (step)
				QS_AB16: z_new[j] = {mix[j][15:0], mix[j][31:16]};
				QS_CD12: z_new[j] = {mix[j][19:0], mix[j][31:20]};
				QS_AB8:  z_new[j] = {mix[j][23:0], mix[j][31:24]};
				QS_CD7:  z_new[j] = {mix[j][24:0], mix[j][31:25]};
				default: z_new[j] = mix[j];
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/chacha20_stream_xor.sv
// chacha20_stream_xor: chacha20 (64-bit nonce, 64-bit counter) word-wide stream xor
// depends on cc20_pkg, cc20_msg_if, cc20_res_if, cc20_qr_unit
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                              handshake
// msg_ch    in   msg_word[31:0] valid_bytes[2:0] last_word            valid/ready
// res_ch    out  cipher_word[31:0] out_bytes[2:0] out_last
//                counter_overflow                                     valid/ready
// apb       in   64-bit registers at byte address 8*i                 psel/penable
//
// a beat at word 0 of a 64-byte block, unless the counter has wrapped, runs the
// block function: rounds on the shared quarter-round unit in ST_ROUND, then the
// feed-forward in ST_FINAL, then ST_EMIT, which registers its result
// every other beat goes through ST_EMIT alone and gives its result in the cycle after
// it; the next beat is taken only back in ST_IDLE, so a new beat is not taken before
// the last one is through; throughput is set by the single quarter-round unit
// reset clears registers, counter, word position and overflow flag; no sweep
// the result register parts the sides: a new beat is taken while the previous
// result drains, and a stalled result only holds off the next beat

module chacha20_stream_xor import cc20_pkg::*; #(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [ADDR_W-1:0]  paddr,
	input  wire  [REG_W-1:0]   pwdata,
	output logic [REG_W-1:0]   prdata,
	output logic               pready,
	cc20_msg_if.sink           msg_ch,
	cc20_res_if.source         res_ch
);

	localparam int RND_W = $clog2(ROUND_COUNT);

	// configuration registers
	logic [REG_W-1:0] key_q [NLANES];
	logic [REG_W-1:0] nonce_q;
	reg_idx_t         reg_sel;
	logic             cfg_wr;

	// sequencer and stream state
	fsm_t             state_q, state_nxt;
	logic [1:0]       step_q;
	logic [RND_W-1:0] rnd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] pos_q;
	logic             ovf_q;

	// held beat
	word_t              msg_q;
	logic [BYTES_W-1:0] vb_q;
	logic               last_q;

	// working state, holds the keystream after the feed-forward
	blk_t  work_q;
	blk_t  init_w;

	// result register
	logic               res_valid_q;
	word_t              cipher_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               last_out_q;
	logic               ovf_out_q;

	logic msg_ready;
	logic msg_take;
	logic need_blk;
	logic last_round;

	// quarter-round routing
	logic [1:0]       xrow, yrow, zrow;
	logic [POS_W-1:0] xi [NLANES];
	logic [POS_W-1:0] yi [NLANES];
	logic [POS_W-1:0] zi [NLANES];
	lane_t            x_l, y_l, z_l, xn_l, zn_l;

	// word update
	logic [CNT_W-1:0] cnt_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic             ovf_nxt;
	logic             ovf_flag;
	word_t            cipher_nxt;

	// ---------------------------------------------------------------- apb
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NLANES; i++) key_q[i] <= '0;
			nonce_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_KEY01: key_q[0] <= pwdata;
				REG_KEY23: key_q[1] <= pwdata;
				REG_KEY45: key_q[2] <= pwdata;
				REG_KEY67: key_q[3] <= pwdata;
				REG_NONCE: nonce_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_KEY01: prdata = key_q[0];
			REG_KEY23: prdata = key_q[1];
			REG_KEY45: prdata = key_q[2];
			REG_KEY67: prdata = key_q[3];
			REG_NONCE: prdata = nonce_q;
			default:   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- initial state
	// constants, key, counter, nonce
	always_comb begin
		for (int i = 0; i < NLANES; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = cnt_q[31:0];
		init_w[13] = cnt_q[63:32];
		init_w[14] = nonce_q[31:0];
		init_w[15] = nonce_q[63:32];
	end

	// ---------------------------------------------------------- sequencer
	assign need_blk   = !ovf_q && (pos_q == '0);
	assign last_round = (step_q == 2'd3) && (rnd_q == RND_W'(ROUND_COUNT - 1));
	assign msg_take   = msg_ch.valid && msg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		msg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// result register empty or draining this cycle
				msg_ready = !res_valid_q || res_ch.ready;
				if (msg_ch.valid && msg_ready) begin
					state_nxt = need_blk ? ST_ROUND : ST_EMIT;
				end
			end
			ST_ROUND: begin
				if (last_round) state_nxt = ST_FINAL;
			end
			ST_FINAL: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign msg_ch.ready = msg_ready;

	// step and round counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			rnd_q  <= '0;
		end else if (msg_take) begin
			step_q <= '0;
			rnd_q  <= '0;
		end else if (state_q == ST_ROUND) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) rnd_q <= rnd_q + RND_W'(1);
		end
	end

	// ------------------------------------------------- shared quarter round
	// odd sub-steps work on c/d, even ones on a/b; odd rounds are diagonal
	always_comb begin
		xrow = step_q[0] ? ROW_C : ROW_A;
		yrow = step_q[0] ? ROW_D : ROW_B;
		zrow = step_q[0] ? ROW_B : ROW_D;
		for (int j = 0; j < NLANES; j++) begin
			xi[j]  = qr_index(xrow, 2'(j), rnd_q[0]);
			yi[j]  = qr_index(yrow, 2'(j), rnd_q[0]);
			zi[j]  = qr_index(zrow, 2'(j), rnd_q[0]);
			x_l[j] = work_q[xi[j]];
			y_l[j] = work_q[yi[j]];
			z_l[j] = work_q[zi[j]];
		end
	end

	cc20_qr_unit u_qr (
		.step  (qstep_t'(step_q)),
		.x     (x_l),
		.y     (y_l),
		.z     (z_l),
		.x_new (xn_l),
		.z_new (zn_l)
	);

	// working state: load, rounds, feed-forward, then shift one word per beat
	always_ff @(posedge clk) begin
		if (msg_take && need_blk) begin
			for (int i = 0; i < NWORDS; i++) work_q[i] <= init_w[i];
		end else begin
			case (state_q)
				ST_ROUND: begin
					for (int j = 0; j < NLANES; j++) begin
						work_q[xi[j]] <= xn_l[j];
						work_q[zi[j]] <= zn_l[j];
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < NWORDS; i++) work_q[i] <= work_q[i] + init_w[i];
				end
				ST_EMIT: begin
					// word 0 always holds the keystream word of the current position
					for (int i = 0; i < NWORDS - 1; i++) work_q[i] <= work_q[i + 1];
					work_q[NWORDS - 1] <= work_q[0];
				end
				default: ;
			endcase
		end
	end

	// held beat
	always_ff @(posedge clk) begin
		if (msg_take) begin
			msg_q  <= msg_ch.msg_word;
			vb_q   <= msg_ch.valid_bytes;
			last_q <= msg_ch.last_word;
		end
	end

	// ------------------------------------------------------- word update
	always_comb begin
		cnt_nxt = cnt_q;
		ovf_nxt = ovf_q;
		pos_nxt = pos_q + POS_W'(1);
		if (pos_q == POS_W'(NWORDS - 1)) begin
			cnt_nxt = cnt_q + CNT_W'(1);
			// counter wraps to zero at the end of the last block
			if (&cnt_q) ovf_nxt = 1'b1;
		end
		ovf_flag = ovf_nxt;
		// a final word restarts the stream
		if (last_q) begin
			cnt_nxt = '0;
			pos_nxt = '0;
			ovf_nxt = 1'b0;
		end
		// once wrapped, words come out as zero
		cipher_nxt = ovf_q ? '0 : ((msg_q ^ work_q[0]) & byte_mask(vb_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			cnt_q <= cnt_nxt;
			pos_q <= pos_nxt;
			ovf_q <= ovf_nxt;
		end
	end

	// ----------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			cipher_q   <= cipher_nxt;
			bytes_q    <= vb_q;
			last_out_q <= last_q;
			ovf_out_q  <= ovf_flag;
		end
	end

	assign res_ch.valid            = res_valid_q;
	assign res_ch.cipher_word      = cipher_q;
	assign res_ch.out_bytes        = bytes_q;
	assign res_ch.out_last         = last_out_q;
	assign res_ch.counter_overflow = ovf_out_q;

	// ---------------------------------------------------------- assertions
	// the result register is free whenever a word is emitted
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !res_valid_q)
		else $error("result register overwritten");

	// feed-forward only after the full round count
	a_final_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINAL |-> $past(state_q) == ST_ROUND && $past(last_round))
		else $error("feed-forward before last round");

	// a beat that needs a block goes through the rounds
	a_blk_start: assert property (@(posedge clk) disable iff (!arst_n)
		msg_take && need_blk |=> state_q == ST_ROUND && step_q == 2'd0 && rnd_q == '0)
		else $error("block start skipped");

endmodule

`default_nettype wire

### bench/chacha20_stream_xor_checker.sv
// chacha20_stream_xor_checker: watches the apb port and both beat channels,
// predicts every result beat and compares it; depends on cc20_pkg and the channel interfaces
`timescale 1ns / 1ps

module chacha20_stream_xor_checker import cc20_pkg::*; #(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [ADDR_W-1:0]  paddr,
	input  wire  [REG_W-1:0]   pwdata,
	input  wire                pready,
	cc20_msg_if                msg_ch,
	cc20_res_if                res_ch,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		word_t              cipher;
		logic [BYTES_W-1:0] nbytes;
		logic               last;
		logic               wrapped;
	} cipher_beat_t;

	// local copy of the key/nonce registers and the stream state
	logic [63:0]     key_reg [4];
	logic [63:0]     nonce_reg;
	logic [CNT_W-1:0] stream_ctr;
	logic [POS_W-1:0] stream_pos;
	logic            wrapped;
	blk_t            ks_words;
	cipher_beat_t    cipher_q [$];
	int              err_total;

	function automatic word_t rotl(word_t v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [127:0] quarter_mix(word_t a, word_t b, word_t c, word_t d);
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		return {a, b, c, d};
	endfunction

	// one 64-byte keystream block for the given counter
	function automatic blk_t make_keystream(logic [CNT_W-1:0] ctr);
		blk_t init_w;
		blk_t w;
		int   a, b, c, d;
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = key_reg[i][31:0];
			init_w[5 + 2 * i] = key_reg[i][63:32];
		end
		init_w[12] = ctr[31:0];
		init_w[13] = ctr[63:32];
		init_w[14] = nonce_reg[31:0];
		init_w[15] = nonce_reg[63:32];
		w = init_w;
		for (int r = 0; r < ROUND_COUNT; r++) begin
			for (int l = 0; l < 4; l++) begin
				a = l;
				b = 4 + l;
				c = 8 + l;
				d = 12 + l;
				// odd rounds work on the diagonals
				if (r % 2 == 1) begin
					b = 4 + ((l + 1) % 4);
					c = 8 + ((l + 2) % 4);
					d = 12 + ((l + 3) % 4);
				end
				{w[a], w[b], w[c], w[d]} = quarter_mix(w[a], w[b], w[c], w[d]);
			end
		end
		for (int i = 0; i < NWORDS; i++)
			w[i] = w[i] + init_w[i];
		return w;
	endfunction

	task automatic flag_field(string what, logic [31:0] want_v, logic [31:0] got_v);
		err_total++;
		$display("%0t result beat %s: expected %h, actual %h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		cipher_beat_t want;
		cipher_beat_t next_beat;
		word_t        mask;
		int           nb;
		if (!arst_n) begin
			key_reg    = '{default: '0};
			nonce_reg  = '0;
			stream_ctr = '0;
			stream_pos = '0;
			wrapped    = 1'b0;
			ks_words   = '{default: '0};
			cipher_q.delete();
			err_total  = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_KEY01: key_reg[0] = pwdata;
					REG_KEY23: key_reg[1] = pwdata;
					REG_KEY45: key_reg[2] = pwdata;
					REG_KEY67: key_reg[3] = pwdata;
					REG_NONCE: nonce_reg = pwdata;
					default: ;
				endcase
			end

			if (res_ch.valid && res_ch.ready) begin
				if (cipher_q.size() == 0) begin
					err_total++;
					$display("%0t result beat with none expected: expected nothing, actual %h",
						$time, res_ch.cipher_word);
				end else begin
					want = cipher_q.pop_front();
					if (res_ch.cipher_word !== want.cipher)
						flag_field("cipher_word", want.cipher, res_ch.cipher_word);
					if (res_ch.out_bytes !== want.nbytes)
						flag_field("out_bytes", 32'(want.nbytes), 32'(res_ch.out_bytes));
					if (res_ch.out_last !== want.last)
						flag_field("out_last", 32'(want.last), 32'(res_ch.out_last));
					if (res_ch.counter_overflow !== want.wrapped)
						flag_field("counter_overflow", 32'(want.wrapped),
							32'(res_ch.counter_overflow));
				end
			end

			if (msg_ch.valid && msg_ch.ready) begin
				nb   = (msg_ch.valid_bytes > 4) ? 4 : int'(msg_ch.valid_bytes);
				mask = (nb == 4) ? '1 : ((32'd1 << (8 * nb)) - 32'd1);
				next_beat.cipher = '0;
				if (!wrapped) begin
					if (stream_pos == '0)
						ks_words = make_keystream(stream_ctr);
					next_beat.cipher = (msg_ch.msg_word ^ ks_words[stream_pos]) & mask;
				end
				if (stream_pos == POS_W'(NWORDS - 1)) begin
					stream_ctr = stream_ctr + 1'b1;
					if (stream_ctr == '0)
						wrapped = 1'b1;
				end
				stream_pos        = stream_pos + 1'b1;
				next_beat.nbytes  = msg_ch.valid_bytes;
				next_beat.last    = msg_ch.last_word;
				next_beat.wrapped = wrapped;
				if (msg_ch.last_word) begin
					stream_ctr = '0;
					stream_pos = '0;
					wrapped    = 1'b0;
				end
				cipher_q.push_back(next_beat);
			end

			fail_count <= err_total;
			pending    <= cipher_q.size();
		end
	end

endmodule

### bench/chacha20_stream_xor_tb.sv
// chacha20_stream_xor_tb: stimulus, idling on both channels, apb key/nonce loads and verdict
// depends on cc20_pkg, cc20_msg_if, cc20_res_if, chacha20_stream_xor, chacha20_stream_xor_checker
`timescale 1ns / 1ps

module chacha20_stream_xor_tb import cc20_pkg::*; ();

	// stop on the total beat count; tail of the run without any idling
	localparam int ITEM_TARGET = 1450;
	localparam int CALM_AFTER  = 1300;
	localparam int PHASE_LEN   = 300;
	// worst beat: a block start plus a full stall on each side;
	// the limit is several times that worst beat over all beats
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_WAIT  = 4 * ROUND_COUNT_DEF + 40;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	int                items_sent;
	int                cycles;
	bit                calm;
	bit                sender_idles;
	bit                paused_once;

	cc20_msg_if msg_ch ();
	cc20_res_if res_ch ();

	chacha20_stream_xor DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.msg_ch  (msg_ch),
		.res_ch  (res_ch)
	);

	chacha20_stream_xor_checker cipher_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.msg_ch     (msg_ch),
		.res_ch     (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stall bursts, quiet stretches, none in the tail
	initial begin : drain_side
		int quiet_run;
		quiet_run = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet_run > 0)
				quiet_run--;
			else if ($urandom_range(0, 63) == 0)
				quiet_run = $urandom_range(20, 300);
			if (!calm && quiet_run == 0 && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// one message beat; returns at the edge where it was taken, valid still high
	task automatic send_beat(word_t w, logic [BYTES_W-1:0] vb, logic lst);
		if (sender_idles && !calm && $urandom_range(0, 6) == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		msg_ch.valid       <= 1'b1;
		msg_ch.msg_word    <= w;
		msg_ch.valid_bytes <= vb;
		msg_ch.last_word   <= lst;
		do @(posedge clk); while (!msg_ch.ready);
		items_sent++;
		if (items_sent >= CALM_AFTER)
			calm = 1'b1;
	endtask

	// drop valid and hold until every predicted result beat has been seen;
	// the first edge lets the checker's count catch up with the last beat
	task automatic wait_drained();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// back-to-back apb writes; caller ends the burst with apb_release
	task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// style 0: all zero, 1: all ones, else a random mix per register
	task automatic load_keys(int style);
		logic [REG_W-1:0] val;
		for (int i = REG_KEY01; i <= REG_NONCE; i++) begin
			case (style)
				0: val = '0;
				1: val = '1;
				default: begin
					case ($urandom_range(0, 5))
						0: val = '0;
						1: val = '1;
						2: val = REG_W'(1) << $urandom_range(0, REG_W - 1);
						default: val = {$urandom, $urandom};
					endcase
				end
			endcase
			write_reg(reg_idx_t'(i), val);
		end
		apb_release();
	endtask

	// mostly well-formed messages (full words, short last word), some broken ones:
	// random byte counts including zero and above four, stray last flags,
	// messages that never end, single-word messages
	task automatic send_message();
		int                 kind;
		int                 len;
		bit                 zero_msg;
		word_t              w;
		logic [BYTES_W-1:0] vb;
		logic               lst;
		kind         = $urandom_range(0, 9);
		zero_msg     = ($urandom_range(0, 4) == 0);
		sender_idles = ($urandom_range(0, 3) != 0);
		case (kind)
			6: len = $urandom_range(33, 80);
			7: len = $urandom_range(1, 30);
			8: len = $urandom_range(1, 20);
			9: len = 1;
			default: len = $urandom_range(1, 40);
		endcase
		for (int i = 0; i < len; i++) begin
			w   = zero_msg ? '0 : word_t'($urandom);
			vb  = 3'd4;
			lst = (i == len - 1);
			if (kind == 7) begin
				vb  = BYTES_W'($urandom_range(0, 7));
				lst = lst || ($urandom_range(0, 15) == 0);
			end else if (kind == 8) begin
				lst = 1'b0;
			end else if (kind == 9) begin
				vb = BYTES_W'($urandom_range(0, 7));
			end else if (lst) begin
				vb = BYTES_W'($urandom_range(1, 4));
			end
			// once, halt the sender inside a message until the block is empty
			if (!paused_once && items_sent > 700 && i == len / 2) begin
				wait_drained();
				paused_once = 1'b1;
			end
			send_beat(w, vb, lst);
		end
	endtask

	initial begin : stimulus
		int phase_mark;
		int phase_no;
		cycles             <= 0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		msg_ch.valid       <= 1'b0;
		msg_ch.msg_word    <= '0;
		msg_ch.valid_bytes <= '0;
		msg_ch.last_word   <= 1'b0;
		items_sent   = 0;
		calm         = 1'b0;
		sender_idles = 1'b1;
		paused_once  = 1'b0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero key and nonce from reset: one full block, then into the next
		send_beat(32'h0000_0000, 3'd4, 1'b0);
		send_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
		// zero byte count, every short count mid-message, counts above four
		send_beat(32'hA5A5_A5A5, 3'd0, 1'b0);
		send_beat(32'h1234_5678, 3'd1, 1'b0);
		send_beat(32'h8765_4321, 3'd2, 1'b0);
		send_beat(32'hDEAD_BEEF, 3'd3, 1'b0);
		send_beat(32'hFFFF_FFFF, 3'd5, 1'b0);
		send_beat(32'h0F0F_0F0F, 3'd6, 1'b0);
		send_beat(32'hF0F0_F0F0, 3'd7, 1'b0);
		for (int i = 9; i < NWORDS; i++)
			send_beat(word_t'($urandom), 3'd4, 1'b0);
		// block counter one, then a short last word restarts the stream
		send_beat(32'h0000_0000, 3'd4, 1'b0);
		send_beat(32'hFFFF_FFFF, 3'd3, 1'b1);
		// single-word messages
		send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_beat(32'hFFFF_FFFF, 3'd0, 1'b1);

		// all-ones key and nonce
		wait_drained();
		load_keys(1);
		send_beat(32'h0000_0000, 3'd4, 1'b0);
		send_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
		send_beat(32'h5555_AAAA, 3'd7, 1'b1);
		// a counter wrap needs 2^64 blocks, out of reach here

		phase_mark = items_sent;
		phase_no   = 0;
		wait_drained();
		load_keys(2);
		while (items_sent < ITEM_TARGET) begin
			// new key/nonce only with the block empty, often mid-block
			if (!calm && items_sent - phase_mark >= PHASE_LEN) begin
				phase_no++;
				wait_drained();
				load_keys(phase_no == 2 ? 0 : 2);
				phase_mark = items_sent;
			end
			send_message();
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
